// File: hdl/rhl_pkg.sv
// rolling hash run linker: shared types, constants and helper functions
// no dependencies; imported by every module of the block except rhl_ram
package rhl_pkg;

  localparam int unsigned MIN_RUN     = 20;
  localparam int unsigned TABLE_SLOTS = 16381;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned ROT_W  = 5;
  localparam int unsigned TOK_W  = 16;
  localparam int unsigned POS_W  = 24;
  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned CNT_W  = $clog2(MIN_RUN + 1);

  // reciprocal for hash mod TABLE_SLOTS: q = (hash * HASH_RECIP) >> HASH_W
  localparam int unsigned RECIP_W = HASH_W + 1 - SLOT_W;
  localparam logic [RECIP_W-1:0] HASH_RECIP =
    RECIP_W'(64'd4294967296 / 64'(TABLE_SLOTS));

  localparam logic [ROT_W-1:0] ROT_RESET     = ROT_W'(5);
  localparam logic [ROT_W-1:0] OLD_ROT_RESET = ROT_W'((5 * (MIN_RUN - 1)) % 32);

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned PEND_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [TOK_W-1:0] token_code;
    logic [POS_W-1:0] token_position;
    logic             text_start;
  } tok_in_t;

  typedef struct packed {
    logic [POS_W-1:0] earlier_start;
    logic [POS_W-1:0] later_start;
  } link_out_t;

  // word after the hash update
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic [HASH_W-1:0] hash;
    logic [POS_W-1:0]  run_start;
  } hash_item_t;

  // word after slot reduction
  typedef struct packed {
    logic              valid;
    logic              emit;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  run_start;
  } slot_item_t;

  function automatic logic [HASH_W-1:0] rotl32(input logic [HASH_W-1:0] v,
                                               input logic [ROT_W-1:0] s);
    logic [2*HASH_W-1:0] t;
    t = {v, v} << s;
    return t[2*HASH_W-1:HASH_W];
  endfunction

endpackage

// File: hdl/rhl_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module rhl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rhl_hash.sv
// token window, run counter and rolling hash update, one token per cycle
// depends on rhl_pkg
module rhl_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rhl_pkg::ROT_W-1:0] cfg_data_i,
  input  logic                     acc_i,
  input  rhl_pkg::tok_in_t         tok_i,
  output rhl_pkg::hash_item_t      item_o
);
  import rhl_pkg::*;

  logic [ROT_W-1:0]  rot_q, rot_d;
  logic [ROT_W-1:0]  old_rot_q, old_rot_d;
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [TOK_W-1:0]  win_q [MIN_RUN];
  logic [TOK_W-1:0]  win_d [MIN_RUN];
  hash_item_t        item_q, item_d;

  logic [HASH_W-1:0] hash_base;
  logic [HASH_W-1:0] hash_mix;
  logic [CNT_W-1:0]  cnt_base;
  logic              full;
  logic              emit;

  always_comb begin
    rot_d     = rot_q;
    old_rot_d = old_rot_q;
    if (cfg_we_i) begin
      rot_d     = cfg_data_i;
      old_rot_d = ROT_W'(cfg_data_i * (MIN_RUN - 1));
    end
  end

  always_comb begin
    hash_base = tok_i.text_start ? '0 : hash_q;
    cnt_base  = tok_i.text_start ? '0 : cnt_q;
    full      = cnt_base >= CNT_W'(MIN_RUN);
    // drop the token leaving the window once it is full
    hash_mix  = hash_base ^ (full ? rotl32(HASH_W'(win_q[0]), old_rot_q) : '0);
    emit      = cnt_base >= CNT_W'(MIN_RUN - 1);

    hash_d = hash_q;
    cnt_d  = cnt_q;
    win_d  = win_q;
    item_d = item_q;
    item_d.valid = acc_i;
    if (acc_i) begin
      hash_d = rotl32(hash_mix, rot_q) ^ HASH_W'(tok_i.token_code);
      cnt_d  = emit ? CNT_W'(MIN_RUN) : cnt_base + CNT_W'(1);
      for (int i = 0; i < MIN_RUN - 1; i++) begin
        win_d[i] = tok_i.text_start ? '0 : win_q[i+1];
      end
      win_d[MIN_RUN-1] = tok_i.token_code;
      item_d.emit      = emit;
      item_d.hash      = hash_d;
      item_d.run_start = tok_i.token_position - POS_W'(MIN_RUN - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q     <= ROT_RESET;
      old_rot_q <= OLD_ROT_RESET;
      hash_q    <= '0;
      cnt_q     <= '0;
      item_q    <= '0;
    end else begin
      rot_q     <= rot_d;
      old_rot_q <= old_rot_d;
      hash_q    <= hash_d;
      cnt_q     <= cnt_d;
      item_q    <= item_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign item_o = item_q;

endmodule

// File: hdl/rhl_slot_mod.sv
// three stage hash mod TABLE_SLOTS: reciprocal multiply, back multiply,
// subtract with one correction; depends on rhl_pkg
module rhl_slot_mod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rhl_pkg::hash_item_t item_i,
  output rhl_pkg::slot_item_t item_o
);
  import rhl_pkg::*;

  localparam int unsigned PROD_W = HASH_W + RECIP_W;
  localparam int unsigned QD_W   = RECIP_W + SLOT_W;

  // stage 1: quotient estimate, low by at most one
  logic              v1_q, e1_q;
  logic [HASH_W-1:0] h1_q;
  logic [POS_W-1:0]  p1_q;
  logic [RECIP_W-1:0] q1_q;
  logic [PROD_W-1:0] prod;

  // stage 2: quotient times divisor
  logic              v2_q, e2_q;
  logic [HASH_W-1:0] h2_q;
  logic [POS_W-1:0]  p2_q;
  logic [HASH_W-1:0] qd2_q;
  logic [QD_W-1:0]   qd_full;

  // stage 3: remainder below twice the divisor, one correction
  logic [SLOT_W:0]   rem;
  logic [SLOT_W-1:0] slot;
  slot_item_t        out_q;

  assign prod    = PROD_W'(item_i.hash) * PROD_W'(HASH_RECIP);
  assign qd_full = QD_W'(q1_q) * QD_W'(TABLE_SLOTS);

  always_comb begin
    rem  = (SLOT_W+1)'(h2_q - qd2_q);
    slot = (rem >= (SLOT_W+1)'(TABLE_SLOTS)) ? SLOT_W'(rem - (SLOT_W+1)'(TABLE_SLOTS))
                                             : SLOT_W'(rem);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      out_q <= '0;
    end else begin
      v1_q            <= item_i.valid;
      v2_q            <= v1_q;
      out_q.valid     <= v2_q;
      out_q.emit      <= e2_q;
      out_q.slot      <= slot;
      out_q.run_start <= p2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e1_q <= item_i.emit;
    h1_q <= item_i.hash;
    p1_q <= item_i.run_start;
    q1_q <= prod[HASH_W +: RECIP_W];

    e2_q  <= e1_q;
    h2_q  <= h1_q;
    p2_q  <= p1_q;
    qd2_q <= HASH_W'(qd_full);
  end

  assign item_o = out_q;

endmodule

// File: hdl/rhl_out_fifo.sv
// small result queue between the slot table stage and the output port
// depends on rhl_pkg; overflow is prevented by the credit count in the top level
module rhl_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rhl_pkg::link_out_t push_data_i,
  input  logic               pop_i,
  output logic               valid_o,
  output rhl_pkg::link_out_t data_o
);
  import rhl_pkg::*;

  link_out_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PEND_W-1:0]      cnt_q, cnt_d;
  logic                   do_pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FIFO_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + PEND_W'(push_i) - PEND_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: hdl/rolling_hash_run_linker.sv
// Rolling hash run linker. Takes one token per clock cycle, sustained while
// in_ready_o is high, and returns a link word for the token when its slot already
// held a nonzero run start. The rolling hash is updated combinationally and registered, the slot is
// found by a three stage reciprocal-multiply reduction, and the slot table is a
// 16381 x 24 single port-pair ram read one cycle and written the next, with
// the write forwarded to an immediately following read of the same slot.
// Results queue in an 8 word buffer; in_ready_o drops once 8 tokens are in
// flight or waiting, so a stalled output stalls input only after that.
// After reset the table is cleared one slot per cycle: in_ready_o stays low until
// every slot is cleared. Configuration writes are taken at any time.
// depends on rhl_pkg, rhl_hash, rhl_slot_mod, rhl_ram, rhl_out_fifo
module rolling_hash_run_linker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rhl_pkg::tok_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rhl_pkg::link_out_t        out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rhl_pkg::ROT_W-1:0] cfg_data_i
);
  import rhl_pkg::*;

  logic       in_acc;
  logic       out_pop;
  hash_item_t hash_item;
  slot_item_t slot_item;

  // table read-modify-write stage
  logic              s4_valid_q, s4_emit_q;
  logic [SLOT_W-1:0] s4_slot_q;
  logic [POS_W-1:0]  s4_run_q;
  logic              fwd_hit_q, fwd_hit_d;
  logic [POS_W-1:0]  fwd_data_q;
  logic [POS_W-1:0]  prev_start;
  logic              push;
  logic              drop;
  link_out_t         push_word;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [POS_W-1:0]  ram_wdata;
  logic              ram_re;
  logic [POS_W-1:0]  ram_rdata;

  logic              clr_q, clr_d;
  logic [SLOT_W-1:0] clr_addr_q, clr_addr_d;
  logic [PEND_W-1:0] pend_q, pend_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !clr_q && (pend_q < PEND_W'(FIFO_DEPTH));
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_pop     = out_valid_o && out_ready_i;

  rhl_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .acc_i      (in_acc),
    .tok_i      (in_data_i),
    .item_o     (hash_item)
  );

  rhl_slot_mod u_slot_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (hash_item),
    .item_o (slot_item)
  );

  always_comb begin
    ram_re    = slot_item.valid && slot_item.emit;
    ram_we    = clr_q || (s4_valid_q && s4_emit_q);
    ram_waddr = clr_q ? clr_addr_q : s4_slot_q;
    ram_wdata = clr_q ? '0 : s4_run_q;
    // read and write of the same slot in one cycle: ram returns stale data
    fwd_hit_d = ram_we && (ram_waddr == slot_item.slot);
  end

  rhl_ram #(
    .WIDTH (POS_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (slot_item.slot),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    prev_start              = fwd_hit_q ? fwd_data_q : ram_rdata;
    push                    = s4_valid_q && s4_emit_q && (prev_start != '0);
    drop                    = s4_valid_q && !push;
    push_word.earlier_start = prev_start;
    push_word.later_start   = s4_run_q;
  end

  rhl_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_word),
    .pop_i       (out_ready_i),
    .valid_o     (out_valid_o),
    .data_o      (out_data_o)
  );

  // tokens accepted whose word is not yet delivered or dropped
  always_comb begin
    pend_d     = pend_q + PEND_W'(in_acc) - PEND_W'(out_pop) - PEND_W'(drop);
    clr_addr_d = clr_addr_q;
    clr_d      = clr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + SLOT_W'(1);
      if (clr_addr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      pend_q     <= '0;
      s4_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      pend_q     <= pend_d;
      s4_valid_q <= slot_item.valid;
      fwd_hit_q  <= fwd_hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_emit_q  <= slot_item.emit;
    s4_slot_q  <= slot_item.slot;
    s4_run_q   <= slot_item.run_start;
    fwd_data_q <= ram_wdata;
  end

endmodule

// File: hdl/rhl_checker.sv
// port level checks for the rolling hash run linker, bound to the top level
// depends on rhl_pkg and rolling_hash_run_linker
module rhl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input rhl_pkg::link_out_t        out_data_o
);
  import rhl_pkg::*;

  // a waiting result word holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result word changed or dropped while stalled");

  // an empty slot never produces a link
  a_earlier_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.earlier_start != '0))
    else $error("link word with zero earlier start");

  // a word appearing on an idle output comes from an earlier accepted token
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 6))
    else $error("result word without matching token");

endmodule

bind rolling_hash_run_linker rhl_checker u_rhl_checker (.*);

// File: verif/tb.sv
// testbench for rolling_hash_run_linker: directed token runs, then phrase-based texts
// under several rotate settings, links checked against an in-bench hash and slot model
// depends on rhl_pkg and rolling_hash_run_linker
`timescale 1ns / 100ps

module tb;
  import rhl_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned PHRASES      = 6;
  localparam int unsigned PH_LEN       = 32;
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned PLAN_LEN     = 12;

  typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_LINK} check_kind_e;

  typedef struct {
    logic [TOK_W-1:0] code;
    logic [TOK_W-1:0] step;
    logic [POS_W-1:0] pos;
    int unsigned      count;
    bit               start;
    check_kind_e      kind;
    logic [POS_W-1:0] early;
    logic [POS_W-1:0] late;
  } plan_row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  tok_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_ready_i;
  link_out_t        out_data_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [ROT_W-1:0] cfg_data_i;

  // hash and slot state mirrored from the block
  logic [HASH_W-1:0] hash_q;
  logic [TOK_W-1:0]  win_q [MIN_RUN];
  int unsigned       fill_q;
  logic [POS_W-1:0]  starts_q [TABLE_SLOTS];
  logic [ROT_W-1:0]  rot_q;

  link_out_t         links_due [$];
  int unsigned       faults;
  int unsigned       cycle_cnt;
  int unsigned       emitted;
  int unsigned       stall_left;
  bit                calm;
  bit                start_due;
  logic [POS_W-1:0]  pos_cursor;
  logic [TOK_W-1:0]  phrase [PHRASES][PH_LEN];

  // code, step, first position, count, text start, check, earlier, later
  plan_row_t plan [PLAN_LEN] = '{
    '{16'hFFFF, 16'h0000, 24'hFFFFFF,  1, 1'b1, EXP_NONE,    24'h0, 24'h0},
    '{16'h0000, 16'h0000, 24'h000000,  1, 1'b0, EXP_NONE,    24'h0, 24'h0},
    // run start zero is stored
    '{16'h00AA, 16'h0000, 24'h000000, 20, 1'b1, EXP_NONE,    24'h0, 24'h0},
    // same window hits the zero entry: no link
    '{16'h00AA, 16'h0000, 24'h000028, 20, 1'b1, EXP_NONE,    24'h0, 24'h0},
    // position wraps past zero, run start wraps below zero
    '{16'h00AA, 16'h0000, 24'hFFFFF0, 20, 1'b1, EXP_LINK,    24'h000028, 24'hFFFFF0},
    '{16'h00AA, 16'h0000, 24'h000004,  3, 1'b0, EXP_PREDICT, 24'h0, 24'h0},
    '{16'h1234, 16'h1111, 24'h000100, 19, 1'b1, EXP_NONE,    24'h0, 24'h0},
    '{16'h5677, 16'h1111, 24'h000113, 12, 1'b0, EXP_PREDICT, 24'h0, 24'h0},
    '{16'hFFFF, 16'h0000, 24'h800000, 25, 1'b1, EXP_PREDICT, 24'h0, 24'h0},
    '{16'h8001, 16'h0101, 24'h7FFFF0, 10, 1'b1, EXP_NONE,    24'h0, 24'h0},
    '{16'h1234, 16'h1111, 24'h200000, 20, 1'b1, EXP_LINK,    24'h000100, 24'h200000},
    '{16'h0000, 16'h0000, 24'h000010, 21, 1'b1, EXP_PREDICT, 24'h0, 24'h0}
  };

  rolling_hash_run_linker i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [HASH_W-1:0] rol(input logic [HASH_W-1:0] v, input int unsigned s);
    s = s % HASH_W;
    if (s == 0) return v;
    return (v << s) | (v >> (HASH_W - s));
  endfunction

  // advance the hash by one token and look up / replace the slot entry
  function automatic void link_token(input tok_in_t word, output bit hit,
                                     output link_out_t lnk);
    logic [TOK_W-1:0] oldest;
    logic [POS_W-1:0] run_start;
    logic [POS_W-1:0] prev;
    int unsigned      slot;
    hit = 1'b0;
    lnk = '0;
    if (word.text_start) begin
      hash_q = '0;
      foreach (win_q[i]) win_q[i] = '0;
      fill_q = 0;
    end
    oldest = win_q[0];
    for (int i = 0; i < MIN_RUN - 1; i++) win_q[i] = win_q[i + 1];
    win_q[MIN_RUN - 1] = word.token_code;
    if (fill_q >= MIN_RUN) hash_q ^= rol(HASH_W'(oldest), (rot_q * (MIN_RUN - 1)) % HASH_W);
    hash_q = rol(hash_q, rot_q);
    hash_q ^= HASH_W'(word.token_code);
    if (fill_q + 1 < MIN_RUN) begin
      fill_q++;
      return;
    end
    fill_q = MIN_RUN;
    run_start = word.token_position - POS_W'(MIN_RUN - 1);
    slot = hash_q % TABLE_SLOTS;
    prev = starts_q[slot];
    starts_q[slot] = run_start;
    if (prev != '0) begin
      hit = 1'b1;
      lnk.earlier_start = prev;
      lnk.later_start = run_start;
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // present one word, wait for the handshake, then record what it should produce
  task automatic feed_token(input tok_in_t word, input bit typed, input bit typed_hit,
                            input link_out_t typed_link);
    int unsigned gap;
    bit          hit;
    link_out_t   lnk;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= word;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    link_token(word, hit, lnk);
    if (typed) begin
      if (typed_hit) links_due.push_back(typed_link);
    end else if (hit) begin
      links_due.push_back(lnk);
    end
  endtask

  task automatic emit(input logic [TOK_W-1:0] code);
    tok_in_t   word;
    link_out_t none;
    word.token_code = code;
    word.token_position = pos_cursor;
    word.text_start = start_due;
    none = '0;
    feed_token(word, 1'b0, 1'b0, none);
    start_due = 1'b0;
    pos_cursor++;
    emitted++;
  endtask

  // texts built mostly from repeated phrase slices so that windows recur,
  // with noise tokens and texts cut short by a new text start
  task automatic run_texts(input int unsigned quota);
    int unsigned pick;
    int unsigned off;
    int unsigned len;
    int unsigned ph;
    emitted = 0;
    for (int p = 0; p < PHRASES; p++) begin
      if ($urandom_range(0, 1) == 0) begin
        for (int k = 0; k < PH_LEN; k++)
          phrase[p][k] = ($urandom_range(0, 3) == 0) ? TOK_W'($urandom_range(0, 15))
                                                     : TOK_W'($urandom);
      end
    end
    while (emitted < quota) begin
      start_due = 1'b1;
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 2) == 0) pos_cursor = POS_W'($urandom);
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(0, 9);
        ph = $urandom_range(0, PHRASES - 1);
        if (pick < 7) begin
          off = $urandom_range(0, 8);
          len = $urandom_range(MIN_RUN, PH_LEN - off);
          for (int k = 0; k < len; k++) emit(phrase[ph][off + k]);
        end else if (pick < 9) begin
          repeat ($urandom_range(1, 6)) emit(TOK_W'($urandom));
        end else begin
          len = $urandom_range(1, MIN_RUN - 1);
          for (int k = 0; k < len; k++) emit(phrase[ph][k]);
          start_due = 1'b1;
        end
      end
    end
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (links_due.size() != 0) @(posedge clk_i);
    // a last word with no link may still be in the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_rot(input logic [ROT_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    rot_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // output side: random back-pressure
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    link_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (links_due.size() == 0) begin
        $display("%0t: link with none expected: expected nothing, got %h -> %h", $time,
                 out_data_o.earlier_start, out_data_o.later_start);
        faults++;
      end else begin
        want = links_due.pop_front();
        if (out_data_o.earlier_start !== want.earlier_start) begin
          $display("%0t: earlier_start expected %h got %h", $time, want.earlier_start,
                   out_data_o.earlier_start);
          faults++;
        end
        if (out_data_o.later_start !== want.later_start) begin
          $display("%0t: later_start expected %h got %h", $time, want.later_start,
                   out_data_o.later_start);
          faults++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    tok_in_t          word;
    link_out_t        lnk;
    logic [TOK_W-1:0] code;
    logic [POS_W-1:0] pos;
    bit               last;
    logic [ROT_W-1:0] rot_steps [6];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    faults = 0;
    cycle_cnt = 0;
    stall_left = 0;
    calm = 1'b0;
    start_due = 1'b1;
    pos_cursor = '0;
    hash_q = '0;
    fill_q = 0;
    rot_q = ROT_RESET;
    foreach (win_q[i]) win_q[i] = '0;
    foreach (starts_q[i]) starts_q[i] = '0;
    foreach (phrase[p, k]) phrase[p][k] = TOK_W'($urandom);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[r]) begin
      code = plan[r].code;
      pos = plan[r].pos;
      lnk.earlier_start = plan[r].early;
      lnk.later_start = plan[r].late;
      for (int k = 0; k < plan[r].count; k++) begin
        word.token_code = code;
        word.token_position = pos;
        word.text_start = plan[r].start && (k == 0);
        last = (k == plan[r].count - 1);
        feed_token(word, plan[r].kind != EXP_PREDICT, plan[r].kind == EXP_LINK && last, lnk);
        code += plan[r].step;
        pos++;
      end
    end

    rot_steps = '{5'd1, 5'd31, 5'd0, ROT_W'($urandom), 5'd16, ROT_W'($urandom)};
    foreach (rot_steps[p]) begin
      go_idle();
      write_rot(rot_steps[p]);
      run_texts(PHASE_ITEMS);
    end
    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (faults == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rhl_pkg.sv
hdl/rhl_ram.sv
hdl/rhl_hash.sv
hdl/rhl_slot_mod.sv
hdl/rhl_out_fifo.sv
hdl/rolling_hash_run_linker.sv
hdl/rhl_checker.sv
verif/tb.sv
